>>> hdl/tfcv_pkg.sv
package tfcv_pkg;

  localparam int unsigned DefStateFrameLen  = 64;
  localparam int unsigned DefNavFrameLen    = 64;
  localparam int unsigned DefDriveStructLen = 64;
  localparam int unsigned DefSizeFieldOffset = 2;
  localparam int unsigned DefMaxFrameLen    = 256;

  localparam int unsigned CountW = 9;
  localparam int unsigned LenW   = 10;

  localparam logic [7:0] LEAD_MARK  = 8'h24;
  localparam logic [7:0] TYPE_STATE = 8'h09;
  localparam logic [7:0] TYPE_NAV   = 8'h08;
  localparam logic [7:0] TYPE_DRIVE = 8'h07;
  localparam logic [7:0] TRAIL_CR   = 8'h0d;
  localparam logic [7:0] TRAIL_LF   = 8'h0a;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_STATE   = 2'd1,
    KIND_NAV     = 2'd2,
    KIND_DRIVE   = 2'd3
  } frame_kind_e;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [7:0]  byte_index;
    logic        frame_done;
    frame_kind_e frame_kind;
    logic        frame_ok;
  } result_t;

endpackage

>>> hdl/typed_frame_checksum_validator.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | data_byte_i, frame_end_i
// out     | output    | out_valid_o/out_ready_i | echo_byte_o, byte_index_o, frame_done_o,
//         |           |                         | frame_kind_o, frame_ok_o
//
// One byte per cycle while in_ready_o is high; each result is registered.
// The frame state and verdict logic sit in front of a two-entry output stage
// (result register plus skid register), which holds each result until it is taken.
// in_ready_o drops only while both output entries are full.
// Reset clears the frame state and empties the output stage.
module typed_frame_checksum_validator #(
  parameter int unsigned STATE_FRAME_LEN   = tfcv_pkg::DefStateFrameLen,
  parameter int unsigned NAV_FRAME_LEN     = tfcv_pkg::DefNavFrameLen,
  parameter int unsigned DRIVE_STRUCT_LEN  = tfcv_pkg::DefDriveStructLen,
  parameter int unsigned SIZE_FIELD_OFFSET = tfcv_pkg::DefSizeFieldOffset,
  parameter int unsigned MAX_FRAME_LEN     = tfcv_pkg::DefMaxFrameLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] echo_byte_o,
  output logic [7:0] byte_index_o,
  output logic       frame_done_o,
  output logic [1:0] frame_kind_o,
  output logic       frame_ok_o
);

  localparam logic [tfcv_pkg::LenW-1:0] StateLen = tfcv_pkg::LenW'(STATE_FRAME_LEN);
  localparam logic [tfcv_pkg::LenW-1:0] NavLen   = tfcv_pkg::LenW'(NAV_FRAME_LEN);
  localparam logic [tfcv_pkg::LenW-1:0] DriveLen = tfcv_pkg::LenW'(DRIVE_STRUCT_LEN + 2);
  localparam logic [15:0] StateSize = 16'(STATE_FRAME_LEN);
  localparam logic [15:0] NavSize   = 16'(NAV_FRAME_LEN);
  localparam logic [15:0] DriveSize = 16'(DRIVE_STRUCT_LEN);
  localparam logic [tfcv_pkg::LenW-1:0] SizeLo   = tfcv_pkg::LenW'(SIZE_FIELD_OFFSET);
  localparam logic [tfcv_pkg::LenW-1:0] SizeHi   = tfcv_pkg::LenW'(SIZE_FIELD_OFFSET + 1);
  localparam logic [tfcv_pkg::LenW-1:0] SizeNeed = tfcv_pkg::LenW'(SIZE_FIELD_OFFSET + 2);
  localparam logic [tfcv_pkg::LenW-1:0] MaxLen   = tfcv_pkg::LenW'(MAX_FRAME_LEN);

  logic [tfcv_pkg::CountW-1:0] count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic        lead_q, lead_d;
  logic [7:0]  recent_q [2];
  logic [7:0]  recent_d [2];
  logic [15:0] size_q, size_d;

  logic                        in_xfer;
  logic [tfcv_pkg::LenW-1:0]   idx_w;
  logic [tfcv_pkg::LenW-1:0]   n_w;
  logic                        over;
  logic                        have_type;
  logic                        have_size;
  logic [7:0]                  body_sum;
  tfcv_pkg::result_t           res;

  tfcv_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    idx_w     = {1'b0, count_q};
    n_w       = idx_w + tfcv_pkg::LenW'(1);
    over      = idx_w >= MaxLen;
    count_d   = count_q;
    lead_d    = lead_q;
    type_d    = type_q;
    size_d    = size_q;
    if (!over) begin
      if (idx_w == '0) begin
        lead_d = (data_byte_i == tfcv_pkg::LEAD_MARK);
      end
      if (idx_w == tfcv_pkg::LenW'(1)) begin
        type_d = data_byte_i;
      end
      if (idx_w == SizeLo) begin
        size_d[7:0] = data_byte_i;
      end
      if (idx_w == SizeHi) begin
        size_d[15:8] = data_byte_i;
      end
      count_d = count_q + tfcv_pkg::CountW'(1);
    end
    sum_d       = sum_q + data_byte_i;
    recent_d[1] = recent_q[0];
    recent_d[0] = data_byte_i;

    have_type = !over && (idx_w >= tfcv_pkg::LenW'(1));
    have_size = !over && (n_w >= SizeNeed);
    body_sum  = sum_q - recent_q[0] - recent_q[1];

    res.echo_byte  = data_byte_i;
    res.byte_index = (idx_w > tfcv_pkg::LenW'(255)) ? 8'hff : idx_w[7:0];
    res.frame_done = frame_end_i;
    res.frame_kind = tfcv_pkg::KIND_UNKNOWN;
    res.frame_ok   = 1'b0;

    if (frame_end_i) begin
      if (lead_d && have_type) begin
        case (type_d)
          tfcv_pkg::TYPE_STATE: begin
            res.frame_kind = tfcv_pkg::KIND_STATE;
            res.frame_ok   = (data_byte_i == sum_q) && (n_w == StateLen) &&
                             have_size && (size_d == StateSize);
          end
          tfcv_pkg::TYPE_NAV: begin
            res.frame_kind = tfcv_pkg::KIND_NAV;
            res.frame_ok   = (data_byte_i == sum_q) && (n_w == NavLen) &&
                             have_size && (size_d == NavSize);
          end
          tfcv_pkg::TYPE_DRIVE: begin
            res.frame_kind = tfcv_pkg::KIND_DRIVE;
            res.frame_ok   = (data_byte_i == tfcv_pkg::TRAIL_LF) &&
                             (recent_q[0] == tfcv_pkg::TRAIL_CR) &&
                             (recent_q[1] == body_sum) && (n_w == DriveLen) &&
                             have_size && (size_d == DriveSize);
          end
          default: begin
            res.frame_kind = tfcv_pkg::KIND_UNKNOWN;
          end
        endcase
      end
      // drop frame state after the last byte
      count_d     = '0;
      sum_d       = '0;
      type_d      = '0;
      lead_d      = 1'b0;
      size_d      = '0;
      recent_d[0] = '0;
      recent_d[1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      type_q      <= '0;
      lead_q      <= 1'b0;
      size_q      <= '0;
      recent_q[0] <= '0;
      recent_q[1] <= '0;
    end else if (in_xfer) begin
      count_q     <= count_d;
      sum_q       <= sum_d;
      type_q      <= type_d;
      lead_q      <= lead_d;
      size_q      <= size_d;
      recent_q[0] <= recent_d[0];
      recent_q[1] <= recent_d[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_xfer) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (out_valid_q && out_ready_i && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign echo_byte_o  = out_q.echo_byte;
  assign byte_index_o = out_q.byte_index;
  assign frame_done_o = out_q.frame_done;
  assign frame_kind_o = out_q.frame_kind;
  assign frame_ok_o   = out_q.frame_ok;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result entry");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, count_q} <= MaxLen)
    else $error("byte count beyond frame limit");

  a_verdict_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.frame_done |-> !out_q.frame_ok &&
      out_q.frame_kind == tfcv_pkg::KIND_UNKNOWN)
    else $error("verdict given on a byte that is not the last");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && frame_end_i |=> count_q == '0 && sum_q == '0)
    else $error("frame state not cleared after last byte");

  a_ok_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && res.frame_ok |-> have_size)
    else $error("frame passed without a complete size field");

endmodule

>>> tb/typed_frame_checksum_validator_tb.sv
module typed_frame_checksum_validator_tb;

  typedef struct packed {
    logic [7:0]            b;
    logic                  e;
    logic                  chk;
    logic [7:0]            idx;
    tfcv_pkg::frame_kind_e kind;
    logic                  ok;
  } dir_row_t;

  localparam int unsigned DirRows = 24;
  localparam int unsigned RandItems = 1300;
  localparam int unsigned LongHold = 200;

  // single-byte frames, bare headers, bad lead, unknown type, short typed frames
  localparam dir_row_t DirTab [DirRows] = '{
    '{8'hff, 1'b1, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h00, 1'b1, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h24, 1'b1, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h24, 1'b0, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h09, 1'b1, 1'b1, 8'd1, tfcv_pkg::KIND_STATE,   1'b0},
    '{8'h24, 1'b0, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h08, 1'b1, 1'b1, 8'd1, tfcv_pkg::KIND_NAV,     1'b0},
    '{8'h24, 1'b0, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h07, 1'b1, 1'b1, 8'd1, tfcv_pkg::KIND_DRIVE,   1'b0},
    '{8'h24, 1'b0, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h55, 1'b1, 1'b1, 8'd1, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h23, 1'b0, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h09, 1'b1, 1'b1, 8'd1, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h24, 1'b0, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h09, 1'b0, 1'b1, 8'd1, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h40, 1'b0, 1'b1, 8'd2, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h00, 1'b0, 1'b1, 8'd3, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h6d, 1'b1, 1'b1, 8'd4, tfcv_pkg::KIND_STATE,   1'b0},
    '{8'h24, 1'b0, 1'b1, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h07, 1'b0, 1'b1, 8'd1, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h0d, 1'b0, 1'b1, 8'd2, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h0a, 1'b1, 1'b1, 8'd3, tfcv_pkg::KIND_DRIVE,   1'b0},
    '{8'h80, 1'b0, 1'b0, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0},
    '{8'h7f, 1'b1, 1'b0, 8'd0, tfcv_pkg::KIND_UNKNOWN, 1'b0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_q = 1'b0;
  logic [7:0] data_byte_q = 8'h00;
  logic       frame_end_q = 1'b0;
  logic       out_ready_q = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] echo_byte;
  logic [7:0] byte_index;
  logic       frame_done;
  logic [1:0] frame_kind;
  logic       frame_ok;

  // frame tracker copy
  logic [tfcv_pkg::CountW-1:0] pr_count = '0;
  logic [7:0]                  pr_sum = '0;
  logic [7:0]                  pr_type = '0;
  logic                        pr_lead = 1'b0;
  logic [7:0]                  pr_recent [3] = '{8'h00, 8'h00, 8'h00};
  logic [15:0]                 pr_size = '0;

  tfcv_pkg::result_t verdict_q [$];
  tfcv_pkg::result_t mon_want;
  logic [7:0]        frame_q [$];
  int unsigned       snd_idle_pct = 0;
  int unsigned       rcv_stall_pct = 0;
  bit                long_hold_req = 1'b0;
  int unsigned       err_cnt = 0;
  int unsigned       items_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       n_good = 0;
  int unsigned       n_bad = 0;
  int unsigned       n_noise = 0;
  int unsigned       n_long = 0;

  typed_frame_checksum_validator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_q),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte_q),
    .frame_end_i  (frame_end_q),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready_q),
    .echo_byte_o  (echo_byte),
    .byte_index_o (byte_index),
    .frame_done_o (frame_done),
    .frame_kind_o (frame_kind),
    .frame_ok_o   (frame_ok)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  function automatic void frame_append(input logic [7:0] b);
    frame_q = {frame_q, b};
  endfunction

  function automatic tfcv_pkg::result_t frame_verdict(input logic [7:0] b, input logic last);
    tfcv_pkg::result_t     r;
    int unsigned           idx;
    int unsigned           n;
    bit                    over;
    bit                    have_type;
    bit                    have_size;
    logic [7:0]            sum_before;
    logic [7:0]            p1;
    logic [7:0]            p2;
    logic [7:0]            body;
    tfcv_pkg::frame_kind_e kind;
    logic                  ok;
    idx = pr_count;
    over = idx >= tfcv_pkg::DefMaxFrameLen;
    sum_before = pr_sum;
    p1 = pr_recent[0];
    p2 = pr_recent[1];
    kind = tfcv_pkg::KIND_UNKNOWN;
    ok = 1'b0;
    if (!over) begin
      if (idx == 0) pr_lead = (b == tfcv_pkg::LEAD_MARK);
      if (idx == 1) pr_type = b;
      if (idx == tfcv_pkg::DefSizeFieldOffset) pr_size[7:0] = b;
      if (idx == tfcv_pkg::DefSizeFieldOffset + 1) pr_size[15:8] = b;
      pr_count = tfcv_pkg::CountW'(idx + 1);
    end
    pr_sum = pr_sum + b;
    pr_recent[2] = pr_recent[1];
    pr_recent[1] = pr_recent[0];
    pr_recent[0] = b;
    if (last) begin
      n = idx + 1;
      have_type = !over && idx >= 1;
      have_size = !over && n >= tfcv_pkg::DefSizeFieldOffset + 2;
      if (pr_lead && have_type) begin
        if (pr_type == tfcv_pkg::TYPE_STATE) begin
          kind = tfcv_pkg::KIND_STATE;
          ok = b == sum_before && n == tfcv_pkg::DefStateFrameLen && have_size &&
               pr_size == tfcv_pkg::DefStateFrameLen;
        end else if (pr_type == tfcv_pkg::TYPE_NAV) begin
          kind = tfcv_pkg::KIND_NAV;
          ok = b == sum_before && n == tfcv_pkg::DefNavFrameLen && have_size &&
               pr_size == tfcv_pkg::DefNavFrameLen;
        end else if (pr_type == tfcv_pkg::TYPE_DRIVE) begin
          body = sum_before - p1 - p2;
          kind = tfcv_pkg::KIND_DRIVE;
          ok = b == tfcv_pkg::TRAIL_LF && p1 == tfcv_pkg::TRAIL_CR && p2 == body &&
               n == tfcv_pkg::DefDriveStructLen + 2 && have_size &&
               pr_size == tfcv_pkg::DefDriveStructLen;
        end
      end
      pr_count = '0;
      pr_sum = '0;
      pr_type = '0;
      pr_lead = 1'b0;
      pr_recent = '{8'h00, 8'h00, 8'h00};
      pr_size = '0;
    end
    r.echo_byte = b;
    r.byte_index = (idx > 255) ? 8'hff : idx[7:0];
    r.frame_done = last;
    r.frame_kind = kind;
    r.frame_ok = ok;
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic e, input logic tab_chk,
                           input tfcv_pkg::result_t tab_want);
    tfcv_pkg::result_t pred;
    logic              took;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_q <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    data_byte_q <= b;
    frame_end_q <= e;
    do begin
      @(negedge clk_i);
      took = in_ready;
      @(posedge clk_i);
    end while (!took);
    pred = frame_verdict(b, e);
    if (tab_chk) pred = tab_want;
    verdict_q = {verdict_q, pred};
    items_sent++;
  endtask

  task automatic send_frame();
    tfcv_pkg::result_t none;
    none = '0;
    foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, none);
  endtask

  task automatic build_good(input int unsigned sel);
    logic [7:0]  typ;
    logic [15:0] size_val;
    logic [7:0]  s;
    int unsigned body_len;
    logic [7:0]  b;
    case (sel)
      0: begin
        typ = tfcv_pkg::TYPE_STATE;
        size_val = 16'(tfcv_pkg::DefStateFrameLen);
        body_len = tfcv_pkg::DefStateFrameLen - 1;
      end
      1: begin
        typ = tfcv_pkg::TYPE_NAV;
        size_val = 16'(tfcv_pkg::DefNavFrameLen);
        body_len = tfcv_pkg::DefNavFrameLen - 1;
      end
      default: begin
        typ = tfcv_pkg::TYPE_DRIVE;
        size_val = 16'(tfcv_pkg::DefDriveStructLen);
        body_len = tfcv_pkg::DefDriveStructLen - 1;
      end
    endcase
    frame_q.delete();
    s = '0;
    for (int unsigned i = 0; i < body_len; i++) begin
      if (i == 0) b = tfcv_pkg::LEAD_MARK;
      else if (i == 1) b = typ;
      else if (i == tfcv_pkg::DefSizeFieldOffset) b = size_val[7:0];
      else if (i == tfcv_pkg::DefSizeFieldOffset + 1) b = size_val[15:8];
      else b = 8'($urandom_range(255));
      frame_append(b);
      s = s + b;
    end
    frame_append(s);
    if (typ == tfcv_pkg::TYPE_DRIVE) begin
      frame_append(tfcv_pkg::TRAIL_CR);
      frame_append(tfcv_pkg::TRAIL_LF);
    end
  endtask

  task automatic pick_type(output logic [7:0] t);
    case ($urandom_range(3))
      0: t = tfcv_pkg::TYPE_STATE;
      1: t = tfcv_pkg::TYPE_NAV;
      2: t = tfcv_pkg::TYPE_DRIVE;
      default: t = 8'($urandom_range(255));
    endcase
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_q <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        out_ready_q <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid && out_ready_q) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        $error("result with no pending byte: echo_byte %0h", echo_byte);
        err_cnt++;
      end else begin
        mon_want = verdict_q.pop_front();
        if (echo_byte !== mon_want.echo_byte) begin
          $error("echo_byte: expected %0h, got %0h", mon_want.echo_byte, echo_byte);
          err_cnt++;
        end
        if (byte_index !== mon_want.byte_index) begin
          $error("byte_index: expected %0d, got %0d", mon_want.byte_index, byte_index);
          err_cnt++;
        end
        if (frame_done !== mon_want.frame_done) begin
          $error("frame_done: expected %0b, got %0b", mon_want.frame_done, frame_done);
          err_cnt++;
        end
        if (frame_kind !== mon_want.frame_kind) begin
          $error("frame_kind: expected %0d, got %0d", mon_want.frame_kind, frame_kind);
          err_cnt++;
        end
        if (frame_ok !== mon_want.frame_ok) begin
          $error("frame_ok: expected %0b, got %0b", mon_want.frame_ok, frame_ok);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    tfcv_pkg::result_t want;
    int unsigned       base;
    int unsigned       phase;
    int unsigned       frame_no;
    int unsigned       pick;
    int unsigned       len;
    int unsigned       pos;
    logic [7:0]        t;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      want = '{echo_byte: DirTab[i].b, byte_index: DirTab[i].idx,
               frame_done: DirTab[i].e, frame_kind: DirTab[i].kind,
               frame_ok: DirTab[i].ok};
      push_byte(DirTab[i].b, DirTab[i].e, DirTab[i].chk, want);
    end

    base = items_sent;
    frame_no = 0;
    long_hold_req = 1'b1;
    while (items_sent < base + RandItems) begin
      phase = (items_sent - base) * 4 / RandItems;
      case (phase)
        0: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct = 81;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 81;
        end
        default: begin
          snd_idle_pct = 8;
          rcv_stall_pct = 8;
        end
      endcase
      pick = $urandom_range(99);
      if (frame_no == 3 || pick >= 97) begin
        len = $urandom_range(2) == 0 ? $urandom_range(258, 300) : $urandom_range(255, 257);
        frame_q.delete();
        frame_append(tfcv_pkg::LEAD_MARK);
        pick_type(t);
        frame_append(t);
        while (frame_q.size() < len) frame_append(8'($urandom_range(255)));
        n_long++;
      end else if (pick < 55) begin
        build_good($urandom_range(2));
        n_good++;
      end else if (pick < 80) begin
        build_good($urandom_range(2));
        case ($urandom_range(3))
          0: begin
            pos = $urandom_range(frame_q.size() - 1);
            frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
          end
          1: frame_q.pop_back();
          2: frame_append(8'($urandom_range(255)));
          default: begin
            pos = tfcv_pkg::DefSizeFieldOffset + $urandom_range(1);
            frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(7));
          end
        endcase
        n_bad++;
      end else begin
        len = $urandom_range(1, 12);
        frame_q.delete();
        for (int unsigned i = 0; i < len; i++) frame_append(8'($urandom_range(255)));
        if ($urandom_range(1)) frame_q[0] = tfcv_pkg::LEAD_MARK;
        if (len > 1 && $urandom_range(1)) begin
          pick_type(t);
          frame_q[1] = t;
        end
        n_noise++;
      end
      send_frame();
      frame_no++;
    end
    in_valid_q <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d bytes in %0d random frames: %0d well-formed, %0d corrupted,",
             items_sent, frame_no, n_good, n_bad);
    $display("%0d short noise, %0d overlong; %0d results checked under four idle mixes",
             n_noise, n_long, results_seen);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
